[sv/dzm_pkg.sv]
// Package for the diamond zone marker: command codes, register indexes,
// configuration and queue item types shared by all modules of the block.
// Depends on nothing.
`default_nettype none

package dzm_pkg;

   // Field widths of one input item and one result item.
   localparam int CMD_W   = 2;
   localparam int POS_W   = 6;
   localparam int COUNT_W = 13;

   // Configuration register widths.
   localparam int RADIUS_W = 5;
   localparam int USED_W   = 7;

   // Bound values span up to 256; diamond coordinates need a sign.
   localparam int LIM_W   = 9;
   localparam int COORD_W = 10;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_RADIUS    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_ROWS_USED = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_COLS_USED = 2'd2;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET    = 5'd1;
   localparam logic [USED_W-1:0]   ROWS_USED_RESET = 7'd64;
   localparam logic [USED_W-1:0]   COLS_USED_RESET = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic [RADIUS_W-1:0] radius;
      logic [USED_W-1:0]   rows_used;
      logic [USED_W-1:0]   cols_used;
   } cfg_type;

   // One classified item as it travels from the front to the back.
   typedef struct packed {
      cmd_type             cmd;
      logic [POS_W-1:0]    row;
      logic [POS_W-1:0]    col;
      logic                walkable;
      logic                in_grid;
      logic [RADIUS_W-1:0] rad;
      coord_type           row_lo;
      coord_type           row_hi;
      logic                has_rows;
      logic [LIM_W-1:0]    col_lim;
   } op_type;

endpackage

`default_nettype wire

[sv/dzm_csr.sv]
// Configuration registers of the diamond zone marker behind an APB-style port.
// Depends on dzm_pkg.
`default_nettype none

module dzm_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [dzm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [dzm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [dzm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready,
   output dzm_pkg::cfg_type                    cfg
);
   import dzm_pkg::*;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Register writes in the access phase.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_RADIUS:    cfg_in.radius    = csr_pwdata[RADIUS_W-1:0];
            REG_ROWS_USED: cfg_in.rows_used = csr_pwdata[USED_W-1:0];
            REG_COLS_USED: cfg_in.cols_used = csr_pwdata[USED_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius    <= RADIUS_RESET;
         cfg_ff.rows_used <= ROWS_USED_RESET;
         cfg_ff.cols_used <= COLS_USED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data; unused addresses read as zero.
   always_comb begin
      unique case (reg_idx)
         REG_RADIUS:    csr_prdata = CSR_DATA_W'(cfg_ff.radius);
         REG_ROWS_USED: csr_prdata = CSR_DATA_W'(cfg_ff.rows_used);
         REG_COLS_USED: csr_prdata = CSR_DATA_W'(cfg_ff.cols_used);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[sv/dzm_front.sv]
// Front of the diamond zone marker: takes an item and classifies it, working
// out bounds and the clipped row range of a diamond. Depends on dzm_pkg.
`default_nettype none

module dzm_front #(
   parameter int GRID_ROWS  = 64,
   parameter int GRID_COLS  = 64,
   parameter int RADIUS_MAX = 31
) (
   input  wire logic                      req_push,
   input  wire logic [dzm_pkg::CMD_W-1:0] req_command,
   input  wire logic [dzm_pkg::POS_W-1:0] req_row,
   input  wire logic [dzm_pkg::POS_W-1:0] req_col,
   input  wire logic                      req_walkable,
   output logic                           req_full,
   input  wire dzm_pkg::cfg_type          cfg,
   output logic                           q_push,
   output dzm_pkg::op_type                q_data,
   input  wire logic                      q_full
);
   import dzm_pkg::*;

   localparam logic [LIM_W-1:0] ROW_CAP = LIM_W'(GRID_ROWS);
   localparam logic [LIM_W-1:0] COL_CAP = LIM_W'(GRID_COLS);
   localparam logic [6:0]       RAD_CAP = 7'(RADIUS_MAX);

   logic [LIM_W-1:0]    row_lim;
   logic [LIM_W-1:0]    col_lim;
   logic [RADIUS_W-1:0] rad;
   coord_type           center;
   coord_type           lo_raw;
   coord_type           hi_raw;
   coord_type           row_max;
   coord_type           row_lo;
   coord_type           row_hi;

   assign req_full = q_full;
   assign q_push   = req_push;

   // Effective bounds and radius.
   always_comb begin
      row_lim = (LIM_W'(cfg.rows_used) < ROW_CAP) ? LIM_W'(cfg.rows_used) : ROW_CAP;
      col_lim = (LIM_W'(cfg.cols_used) < COL_CAP) ? LIM_W'(cfg.cols_used) : COL_CAP;
      rad     = (7'(cfg.radius) > RAD_CAP) ? RADIUS_W'(RAD_CAP) : cfg.radius;
   end

   // Rows of the diamond that fall inside the bounds.
   always_comb begin
      center  = coord_type'(req_row);
      lo_raw  = center - coord_type'(rad);
      hi_raw  = center + coord_type'(rad);
      row_max = coord_type'(row_lim) - coord_type'(1);
      row_lo  = (lo_raw < coord_type'(0)) ? coord_type'(0) : lo_raw;
      row_hi  = (hi_raw > row_max) ? row_max : hi_raw;
   end

   always_comb begin
      q_data.cmd      = cmd_type'(req_command);
      q_data.row      = req_row;
      q_data.col      = req_col;
      q_data.walkable = req_walkable;
      q_data.in_grid  = (LIM_W'(req_row) < ROW_CAP) && (LIM_W'(req_col) < COL_CAP);
      q_data.rad      = rad;
      q_data.row_lo   = row_lo;
      q_data.row_hi   = row_hi;
      q_data.has_rows = (row_lo <= row_hi);
      q_data.col_lim  = col_lim;
   end

endmodule

`default_nettype wire

[sv/dzm_queue.sv]
// Short queue of classified items between the front and the back of the
// diamond zone marker. Depends on dzm_pkg.
`default_nettype none

module dzm_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire dzm_pkg::op_type push_data,
   output logic                 full,
   input  wire logic            pop,
   output dzm_pkg::op_type      head,
   output logic                 empty
);
   import dzm_pkg::*;

   op_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QPTR_W:0]     count_ff;
   logic [QPTR_W:0]     count_in;
   logic                push_ok;
   logic                pop_ok;

   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push & ~full;
   assign pop_ok  = pop & ~empty;
   assign head    = entry_ff[rd_ptr_ff];

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push_ok) - (QPTR_W+1)'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Item storage.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[sv/dzm_back.sv]
// Back of the diamond zone marker: holds the walkability and zone memories,
// carries out one item at a time and keeps the result register.
// Depends on dzm_pkg.
`default_nettype none

module dzm_back #(
   parameter int GRID_ROWS = 64,
   parameter int GRID_COLS = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dzm_pkg::op_type             q_head,
   input  wire logic                        q_empty,
   output logic                             q_pop,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output logic                             rsp_in_zone,
   output logic [dzm_pkg::COUNT_W-1:0]      rsp_new_cells,
   output logic [dzm_pkg::COUNT_W-1:0]      rsp_zone_size
);
   import dzm_pkg::*;

   localparam int RA_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int CA_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int CNT_W = $clog2(GRID_COLS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_RUN,
      ST_ADD_DRAIN,
      ST_CELL_READ,
      ST_CELL_DONE
   } state_type;

   // Row-wide memories.
   logic [GRID_COLS-1:0] zone_mem [GRID_ROWS];
   logic [GRID_COLS-1:0] walk_mem [GRID_ROWS];

   // Control state.
   state_type            state_ff;
   state_type            state_in;
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic                 s2_valid_ff;
   logic                 s2_valid_in;
   logic [COUNT_W-1:0]   added_ff;
   logic [COUNT_W-1:0]   added_in;
   logic [COUNT_W-1:0]   zone_count_ff;
   logic [COUNT_W-1:0]   zone_count_in;
   logic [GRID_ROWS-1:0] zone_valid_ff;
   logic [GRID_ROWS-1:0] zone_valid_in;
   logic [GRID_ROWS-1:0] walk_valid_ff;
   logic [GRID_ROWS-1:0] walk_valid_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 rsp_in_zone_ff;
   logic                 rsp_in_zone_in;
   logic [COUNT_W-1:0]   rsp_new_cells_ff;
   logic [COUNT_W-1:0]   rsp_new_cells_in;
   logic [COUNT_W-1:0]   rsp_zone_size_ff;
   logic [COUNT_W-1:0]   rsp_zone_size_in;

   // Payload registers.
   op_type               op_ff;
   op_type               op_in;
   logic [RA_W-1:0]      cur_row_ff;
   logic [RA_W-1:0]      cur_row_in;
   logic [RA_W-1:0]      s1_row_ff;
   logic [GRID_COLS-1:0] mask_ff;
   logic [GRID_COLS-1:0] new_ff;
   logic [GRID_COLS-1:0] zone_rd_ff;
   logic [GRID_COLS-1:0] walk_rd_ff;
   logic                 zone_rv_ff;
   logic                 walk_rv_ff;

   // Combinational helpers.
   logic                 slot_free;
   logic                 pop_ok;
   logic                 zone_we;
   logic                 walk_we;
   logic [CA_W-1:0]      col_idx;
   coord_type            dr;
   coord_type            abs_dr;
   coord_type            span;
   coord_type            col_lo;
   coord_type            col_hi;
   logic [GRID_COLS-1:0] row_mask;
   logic [GRID_COLS-1:0] zone_old;
   logic [GRID_COLS-1:0] walk_old;
   logic [GRID_COLS-1:0] new_bits;
   logic [GRID_COLS-1:0] zone_wdata;
   logic [GRID_COLS-1:0] walk_wdata;
   logic [CNT_W-1:0]     new_count;

   assign pop_ok    = rsp_pop & rsp_valid_ff;
   assign slot_free = ~rsp_valid_ff | pop_ok;
   assign col_idx   = CA_W'(op_ff.col);

   // Column mask of the diamond on the row being issued.
   always_comb begin
      dr     = coord_type'(cur_row_ff) - coord_type'(op_ff.row);
      abs_dr = (dr < coord_type'(0)) ? -dr : dr;
      span   = coord_type'(op_ff.rad) - abs_dr;
      col_lo = coord_type'(op_ff.col) - span;
      col_hi = coord_type'(op_ff.col) + span;
      for (int c = 0; c < GRID_COLS; c++) begin
         row_mask[c] = (coord_type'(c) >= col_lo) && (coord_type'(c) <= col_hi) &&
                       (LIM_W'(c) < op_ff.col_lim);
      end
   end

   // Read-modify-write of one row; rows never written read as zero.
   always_comb begin
      zone_old   = zone_rv_ff ? zone_rd_ff : '0;
      walk_old   = walk_rv_ff ? walk_rd_ff : '0;
      new_bits   = walk_old & ~zone_old & mask_ff;
      zone_wdata = zone_old | new_bits;
      walk_wdata = walk_old;
      walk_wdata[col_idx] = op_ff.walkable;
   end

   // Count of cells newly marked on one row.
   always_comb begin
      new_count = '0;
      for (int i = 0; i < GRID_COLS; i++) begin
         new_count = new_count + CNT_W'(new_ff[i]);
      end
   end

   // Sequencer: next state, counters, valid bits and result register.
   always_comb begin
      state_in         = state_ff;
      op_in            = op_ff;
      cur_row_in       = cur_row_ff;
      s1_valid_in      = 1'b0;
      s2_valid_in      = s1_valid_ff;
      added_in         = s2_valid_ff ? added_ff + COUNT_W'(new_count) : added_ff;
      zone_count_in    = zone_count_ff;
      zone_valid_in    = zone_valid_ff;
      walk_valid_in    = walk_valid_ff;
      rsp_valid_in     = rsp_valid_ff & ~pop_ok;
      rsp_in_zone_in   = rsp_in_zone_ff;
      rsp_new_cells_in = rsp_new_cells_ff;
      rsp_zone_size_in = rsp_zone_size_ff;
      q_pop            = 1'b0;
      zone_we          = s1_valid_ff;
      walk_we          = 1'b0;

      if (s1_valid_ff) begin
         zone_valid_in[s1_row_ff] = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty && slot_free) begin
               q_pop = 1'b1;
               op_in = q_head;
               unique case (q_head.cmd)
                  CMD_WRITE, CMD_QUERY: begin
                     if (q_head.in_grid) begin
                        cur_row_in = RA_W'(q_head.row);
                        state_in   = ST_CELL_READ;
                     end else begin
                        rsp_valid_in     = 1'b1;
                        rsp_in_zone_in   = 1'b0;
                        rsp_new_cells_in = '0;
                        rsp_zone_size_in = zone_count_ff;
                     end
                  end
                  CMD_ADD: begin
                     if (q_head.has_rows) begin
                        cur_row_in = RA_W'(q_head.row_lo);
                        added_in   = '0;
                        state_in   = ST_ADD_RUN;
                     end else begin
                        rsp_valid_in     = 1'b1;
                        rsp_in_zone_in   = 1'b0;
                        rsp_new_cells_in = '0;
                        rsp_zone_size_in = zone_count_ff;
                     end
                  end
                  CMD_CLEAR: begin
                     zone_valid_in    = '0;
                     zone_count_in    = '0;
                     rsp_valid_in     = 1'b1;
                     rsp_in_zone_in   = 1'b0;
                     rsp_new_cells_in = '0;
                     rsp_zone_size_in = '0;
                  end
               endcase
            end
         end
         ST_ADD_RUN: begin
            // One diamond row enters the read-modify-write pipeline per cycle.
            s1_valid_in = 1'b1;
            if (cur_row_ff == RA_W'(op_ff.row_hi)) begin
               state_in = ST_ADD_DRAIN;
            end else begin
               cur_row_in = cur_row_ff + RA_W'(1);
            end
         end
         ST_ADD_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               zone_count_in    = zone_count_ff + added_ff;
               rsp_valid_in     = 1'b1;
               rsp_in_zone_in   = 1'b0;
               rsp_new_cells_in = added_ff;
               rsp_zone_size_in = zone_count_ff + added_ff;
               state_in         = ST_IDLE;
            end
         end
         ST_CELL_READ: begin
            state_in = ST_CELL_DONE;
         end
         ST_CELL_DONE: begin
            rsp_valid_in     = 1'b1;
            rsp_new_cells_in = '0;
            rsp_zone_size_in = zone_count_ff;
            if (op_ff.cmd == CMD_WRITE) begin
               walk_we                   = 1'b1;
               walk_valid_in[cur_row_ff] = 1'b1;
               rsp_in_zone_in            = 1'b0;
            end else begin
               rsp_in_zone_in = zone_rv_ff & zone_rd_ff[col_idx];
            end
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         added_ff         <= '0;
         zone_count_ff    <= '0;
         zone_valid_ff    <= '0;
         walk_valid_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
         rsp_in_zone_ff   <= 1'b0;
         rsp_new_cells_ff <= '0;
         rsp_zone_size_ff <= '0;
      end else begin
         state_ff         <= state_in;
         s1_valid_ff      <= s1_valid_in;
         s2_valid_ff      <= s2_valid_in;
         added_ff         <= added_in;
         zone_count_ff    <= zone_count_in;
         zone_valid_ff    <= zone_valid_in;
         walk_valid_ff    <= walk_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         rsp_in_zone_ff   <= rsp_in_zone_in;
         rsp_new_cells_ff <= rsp_new_cells_in;
         rsp_zone_size_ff <= rsp_zone_size_in;
      end
   end

   // Pipeline payload: issued row and its mask, then the new cells.
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      cur_row_ff <= cur_row_in;
      s1_row_ff  <= cur_row_ff;
      mask_ff    <= row_mask;
      new_ff     <= new_bits;
      zone_rv_ff <= zone_valid_ff[cur_row_ff];
      walk_rv_ff <= walk_valid_ff[cur_row_ff];
   end

   // Memories: one write and one registered read each per cycle.
   always_ff @(posedge clock) begin
      if (zone_we) begin
         zone_mem[s1_row_ff] <= zone_wdata;
      end
      zone_rd_ff <= zone_mem[cur_row_ff];
   end

   always_ff @(posedge clock) begin
      if (walk_we) begin
         walk_mem[cur_row_ff] <= walk_wdata;
      end
      walk_rd_ff <= walk_mem[cur_row_ff];
   end

   assign rsp_empty     = ~rsp_valid_ff;
   assign rsp_in_zone   = rsp_in_zone_ff;
   assign rsp_new_cells = rsp_new_cells_ff;
   assign rsp_zone_size = rsp_zone_size_ff;

endmodule

`default_nettype wire

[sv/diamond_zone_marker_top.sv]
// Top level of the diamond zone marker: configuration registers, front,
// item queue and back. Depends on dzm_pkg, dzm_csr, dzm_front, dzm_queue, dzm_back.
//
// The block keeps a walkability bitmap and a zone bitmap, each a memory of one
// word per grid row. Items enter through a queue-like port (push/full) and every
// item gives one result on a queue-like port (empty/pop). A front stage
// classifies each item and clips the diamond to the bounds; a two-entry queue
// lets it keep accepting while the back works. The back carries out one item
// at a time: a clear, or an add point with no diamond row in bounds, is answered
// from the idle state; a walkability write or a query reads its row and then
// writes it or answers; an add point runs each in-bounds diamond row through
// the zone memory port, which does one row-wide read-modify-write per cycle.
// A new item starts in the back once the previous result has been taken or is
// being taken. Both bitmaps read as empty after reset via per-row valid bits,
// so there is no clearing pass; a clear item empties the zone the same way.
// The user writes configuration only while the block is idle; not enforced.
`default_nettype none

module diamond_zone_marker_top #(
   parameter int GRID_ROWS  = 64,
   parameter int GRID_COLS  = 64,
   parameter int RADIUS_MAX = 31
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic [dzm_pkg::CMD_W-1:0]      req_command,
   input  wire logic [dzm_pkg::POS_W-1:0]      req_row,
   input  wire logic [dzm_pkg::POS_W-1:0]      req_col,
   input  wire logic                           req_walkable,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic                                rsp_in_zone,
   output logic      [dzm_pkg::COUNT_W-1:0]    rsp_new_cells,
   output logic      [dzm_pkg::COUNT_W-1:0]    rsp_zone_size,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [dzm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [dzm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [dzm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);
   import dzm_pkg::*;

   cfg_type cfg;
   op_type  push_data;
   op_type  head;
   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;

   dzm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dzm_front #(
      .GRID_ROWS  (GRID_ROWS),
      .GRID_COLS  (GRID_COLS),
      .RADIUS_MAX (RADIUS_MAX)
   ) u_front (
      .req_push     (req_push),
      .req_command  (req_command),
      .req_row      (req_row),
      .req_col      (req_col),
      .req_walkable (req_walkable),
      .req_full     (req_full),
      .cfg          (cfg),
      .q_push       (q_push),
      .q_data       (push_data),
      .q_full       (q_full)
   );

   dzm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (head),
      .empty     (q_empty)
   );

   dzm_back #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_head        (head),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_in_zone   (rsp_in_zone),
      .rsp_new_cells (rsp_new_cells),
      .rsp_zone_size (rsp_zone_size)
   );

endmodule

`default_nettype wire

[tb/diamond_zone_marker_top_tb.sv]
// Self-checking testbench for diamond_zone_marker_top: queue-side drivers, an APB
// register driver and a scoreboard class that tracks the walk and zone bitmaps.
// Depends on dzm_pkg and diamond_zone_marker_top.
`default_nettype none

module diamond_zone_marker_top_tb;
   import dzm_pkg::*;

   localparam int GRID_ROWS      = 64;
   localparam int GRID_COLS      = 64;
   localparam int RADIUS_MAX     = 31;
   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 10;
   localparam int SETTLE_CYCLES  = 100;
   localparam int TIMEOUT_CYCLES = 800000;
   localparam int PHASE_ITEMS    = 120;
   localparam int PHASES         = 10;
   localparam int MAX_WAIT       = 19;

   // One expected result item.
   typedef struct {
      logic               in_zone;
      logic [COUNT_W-1:0] new_cells;
      logic [COUNT_W-1:0] zone_size;
   } zone_result_type;

   // Tracks walkability, zone and registers, and checks result items in order.
   class zone_scoreboard;
      bit [GRID_COLS-1:0] walk_rows [GRID_ROWS];
      bit [GRID_COLS-1:0] zone_rows [GRID_ROWS];
      int unsigned        zone_total;
      int unsigned        radius;
      int unsigned        rows_used;
      int unsigned        cols_used;
      zone_result_type    awaited_results [$];
      int unsigned        mismatches;
      int unsigned        results_checked;
      int unsigned        zone_hits;
      int unsigned        cmd_count [4];

      function new();
         foreach (walk_rows[r]) begin
            walk_rows[r] = '0;
            zone_rows[r] = '0;
         end
         zone_total = 0;
         radius     = RADIUS_RESET;
         rows_used  = ROWS_USED_RESET;
         cols_used  = COLS_USED_RESET;
      endfunction

      function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_RADIUS:    radius    = value[RADIUS_W-1:0];
            REG_ROWS_USED: rows_used = value[USED_W-1:0];
            REG_COLS_USED: cols_used = value[USED_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned reg_value(logic [REG_IDX_W-1:0] idx);
         case (idx)
            REG_RADIUS:    return radius;
            REG_ROWS_USED: return rows_used;
            REG_COLS_USED: return cols_used;
            default:       return 0;
         endcase
      endfunction

      // Marks walkable in-bounds cells of the diamond; returns how many were new.
      function int unsigned paint_diamond(int cr, int cc);
         int          rlim;
         int          clim;
         int          rad;
         int          span;
         int          r;
         int          dr;
         int          c;
         int unsigned added;
         rlim  = (rows_used < GRID_ROWS) ? int'(rows_used) : GRID_ROWS;
         clim  = (cols_used < GRID_COLS) ? int'(cols_used) : GRID_COLS;
         rad   = (radius > RADIUS_MAX) ? RADIUS_MAX : int'(radius);
         added = 0;
         for (dr = -rad; dr <= rad; dr++) begin
            r    = cr + dr;
            span = rad - ((dr < 0) ? -dr : dr);
            if (r < 0 || r >= rlim) continue;
            for (c = cc - span; c <= cc + span; c++) begin
               if (c < 0 || c >= clim) continue;
               if (walk_rows[r][c] && !zone_rows[r][c]) begin
                  zone_rows[r][c] = 1'b1;
                  added++;
               end
            end
         end
         return added;
      endfunction

      // Applies one accepted item and queues the result it must produce.
      // Row and column fields cannot leave the grid store, so no store check.
      function void note_item(cmd_type cmd, logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                              logic walk);
         zone_result_type res;
         int unsigned     added;
         res.in_zone   = 1'b0;
         res.new_cells = '0;
         cmd_count[int'(cmd)]++;
         case (cmd)
            CMD_WRITE: walk_rows[row][col] = walk;
            CMD_ADD: begin
               added         = paint_diamond(int'(row), int'(col));
               zone_total   += added;
               res.new_cells = COUNT_W'(added);
            end
            CMD_QUERY: res.in_zone = zone_rows[row][col];
            CMD_CLEAR: begin
               foreach (zone_rows[r]) zone_rows[r] = '0;
               zone_total = 0;
            end
            default: ;
         endcase
         res.zone_size   = COUNT_W'(zone_total);
         awaited_results = {awaited_results, res};
      endfunction

      function void compare_field(string what, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(logic in_zone, logic [COUNT_W-1:0] new_cells,
                                 logic [COUNT_W-1:0] zone_size);
         zone_result_type want;
         results_checked++;
         if (awaited_results.size() == 0) begin
            $display("%0t: result item with none outstanding: in_zone %0d",
                     $time, in_zone);
            $display("   new_cells %0d zone_size %0d", new_cells, zone_size);
            mismatches++;
            return;
         end
         want = awaited_results.pop_front();
         if (want.in_zone) zone_hits++;
         compare_field("in_zone", 32'(want.in_zone), 32'(in_zone));
         compare_field("new_cells", 32'(want.new_cells), 32'(new_cells));
         compare_field("zone_size", 32'(want.zone_size), 32'(zone_size));
      endfunction
   endclass

   logic                  clock;
   logic                  reset        = 1'b1;
   logic                  req_push     = 1'b0;
   logic                  req_full;
   logic [CMD_W-1:0]      req_command  = '0;
   logic [POS_W-1:0]      req_row      = '0;
   logic [POS_W-1:0]      req_col      = '0;
   logic                  req_walkable = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_pop      = 1'b0;
   logic                  rsp_in_zone;
   logic [COUNT_W-1:0]    rsp_new_cells;
   logic [COUNT_W-1:0]    rsp_zone_size;
   logic                  csr_psel     = 1'b0;
   logic                  csr_penable  = 1'b0;
   logic                  csr_pwrite   = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr    = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata   = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   zone_scoreboard zone_sb;
   bit             traffic_open;
   bit             send_calm;
   bit             pop_calm;
   int unsigned    items_sent;
   int unsigned    settings_applied;

   diamond_zone_marker_top u_top (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_command   (req_command),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_walkable  (req_walkable),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_in_zone   (rsp_in_zone),
      .rsp_new_cells (rsp_new_cells),
      .rsp_zone_size (rsp_zone_size),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always begin
      clock = 1'b0;
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
   end

   // Pushes one item after a random gap; called and returns at a falling edge.
   task automatic send_item(cmd_type cmd, logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                            logic walk);
      int gap;
      gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push     = 1'b1;
      req_command  = cmd;
      req_row      = row;
      req_col      = col;
      req_walkable = walk;
      forever begin
         @(posedge clock);
         if (!req_full) break;
      end
      zone_sb.note_item(cmd, row, col, walk);
      @(negedge clock);
      req_push = 1'b0;
      items_sent++;
      if (items_sent % 50 == 0) send_calm = ($urandom_range(0, 2) == 0);
   endtask

   // APB write: setup cycle, then access until pready.
   task automatic csr_write(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      forever begin
         @(posedge clock);
         if (csr_pready) break;
      end
      zone_sb.write_reg(idx, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // APB read of one register, checked against the tracked value.
   task automatic csr_readback(logic [REG_IDX_W-1:0] idx);
      logic [CSR_DATA_W-1:0] got;
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = CSR_ADDR_W'({idx, 2'b00});
      @(negedge clock);
      csr_penable = 1'b1;
      forever begin
         @(posedge clock);
         if (csr_pready) break;
      end
      got = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      zone_sb.compare_field("register readback", zone_sb.reg_value(idx), got);
   endtask

   task automatic wait_idle();
      while (zone_sb.awaited_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Registers change only once every result has been taken.
   task automatic apply_setting(int rad, int rows, int cols);
      wait_idle();
      csr_write(REG_RADIUS, rad);
      csr_write(REG_ROWS_USED, rows);
      csr_write(REG_COLS_USED, cols);
      csr_readback(REG_RADIUS);
      csr_readback(REG_ROWS_USED);
      csr_readback(REG_COLS_USED);
      settings_applied++;
   endtask

   // Corners, repeated marking, blocked cells, map change after marking and clear.
   task automatic run_directed();
      send_item(CMD_WRITE, 0, 0, 1'b1);
      send_item(CMD_WRITE, 0, 1, 1'b1);
      send_item(CMD_WRITE, 1, 0, 1'b1);
      send_item(CMD_WRITE, 1, 1, 1'b0);
      send_item(CMD_WRITE, 63, 63, 1'b1);
      send_item(CMD_WRITE, 62, 63, 1'b1);
      send_item(CMD_QUERY, 0, 0, 1'b0);
      send_item(CMD_ADD, 0, 0, 1'b0);
      send_item(CMD_ADD, 0, 0, 1'b1);
      send_item(CMD_QUERY, 0, 0, 1'b0);
      send_item(CMD_QUERY, 1, 1, 1'b0);
      send_item(CMD_ADD, 63, 63, 1'b0);
      send_item(CMD_WRITE, 63, 63, 1'b0);
      send_item(CMD_QUERY, 63, 63, 1'b0);
      send_item(CMD_ADD, 62, 62, 1'b0);
      send_item(CMD_QUERY, 42, 21, 1'b1);
      send_item(CMD_QUERY, 21, 42, 1'b0);
      send_item(CMD_CLEAR, 63, 63, 1'b1);
      send_item(CMD_QUERY, 0, 0, 1'b0);
      send_item(CMD_ADD, 0, 1, 1'b0);
      send_item(CMD_WRITE, 0, 0, 1'b0);
      send_item(CMD_QUERY, 0, 0, 1'b0);
      send_item(CMD_CLEAR, 0, 0, 1'b0);
   endtask

   // Mostly items within a 16x16 window; fill runs make the window walkable first.
   task automatic random_item(int focus_r, int focus_c, bit fill);
      int               pick;
      cmd_type          cmd;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             walk;
      pick = $urandom_range(0, 99);
      if (fill || pick < 35)  cmd = CMD_WRITE;
      else if (pick < 65)     cmd = CMD_ADD;
      else if (pick < 96)     cmd = CMD_QUERY;
      else                    cmd = CMD_CLEAR;
      if ($urandom_range(0, 4) == 0) begin
         row = POS_W'($urandom_range(0, GRID_ROWS - 1));
         col = POS_W'($urandom_range(0, GRID_COLS - 1));
      end else begin
         row = POS_W'(focus_r + $urandom_range(0, 15));
         col = POS_W'(focus_c + $urandom_range(0, 15));
      end
      walk = fill ? ($urandom_range(0, 7) != 0) : 1'($urandom_range(0, 1));
      send_item(cmd, row, col, walk);
   endtask

   // The window moves every 40 items, often onto the edge of the bounds.
   task automatic run_phase(int count);
      int k;
      int lim_r;
      int lim_c;
      int focus_r;
      int focus_c;
      focus_r = 0;
      focus_c = 0;
      for (k = 0; k < count; k++) begin
         if (k % 40 == 0) begin
            lim_r   = (zone_sb.rows_used < GRID_ROWS) ? int'(zone_sb.rows_used) : GRID_ROWS;
            lim_c   = (zone_sb.cols_used < GRID_COLS) ? int'(zone_sb.cols_used) : GRID_COLS;
            focus_r = $urandom_range(0, 1) ? $urandom_range(0, GRID_ROWS - 1)
                                           : ((lim_r > 8) ? lim_r - 8 : 0);
            focus_c = $urandom_range(0, 1) ? $urandom_range(0, GRID_COLS - 1)
                                           : ((lim_c > 8) ? lim_c - 8 : 0);
         end
         random_item(focus_r, focus_c, (k % 40) < 16);
      end
   endtask

   // Result side: random stall per item, then pop until one is taken.
   initial begin : result_drain
      int          stall;
      int unsigned popped;
      wait (traffic_open);
      @(negedge clock);
      forever begin
         stall = pop_calm ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_pop = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop = 1'b1;
         forever begin
            @(posedge clock);
            if (!rsp_empty) break;
         end
         zone_sb.check_result(rsp_in_zone, rsp_new_cells, rsp_zone_size);
         @(negedge clock);
         popped++;
         if (popped % 50 == 0) pop_calm = ($urandom_range(0, 2) == 0);
      end
   end

   initial begin : stimulus
      int ph;
      zone_sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset        = 1'b0;
      traffic_open = 1'b1;

      run_directed();
      run_phase(PHASE_ITEMS);

      // Register settings: radius extremes, empty bounds, oversized and thin bounds.
      for (ph = 1; ph < PHASES; ph++) begin
         case (ph)
            1:       apply_setting(0, 64, 64);
            2:       apply_setting(31, 64, 64);
            3:       apply_setting(3, 0, 0);
            4:       apply_setting(2, 127, 1);
            5:       apply_setting(7, 1, 127);
            6:       apply_setting(4, 20, 33);
            7:       apply_setting(31, 64, 64);
            default: apply_setting($urandom_range(0, 31), $urandom_range(0, 127),
                                   $urandom_range(0, 127));
         endcase
         run_phase(PHASE_ITEMS);
      end
      req_push = 1'b0;

      while (zone_sb.awaited_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Covered %0d items over %0d register settings: %0d writes, %0d diamonds,",
               items_sent, settings_applied + 1, zone_sb.cmd_count[CMD_WRITE],
               zone_sb.cmd_count[CMD_ADD]);
      $display("%0d queries (%0d in zone) and %0d clears.", zone_sb.cmd_count[CMD_QUERY],
               zone_sb.zone_hits, zone_sb.cmd_count[CMD_CLEAR]);
      $display("Checked %0d result items, %0d mismatches.", zone_sb.results_checked,
               zone_sb.mismatches);
      if (zone_sb.mismatches == 0 && zone_sb.awaited_results.size() == 0) begin
         $display("diamond_zone_marker_top verification clean");
      end else begin
         if (zone_sb.awaited_results.size() != 0)
            $display("%0t: %0d result items never arrived", $time,
                     zone_sb.awaited_results.size());
         $display("diamond_zone_marker_top verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
      $display("%0t: timeout", $time);
      $display("diamond_zone_marker_top verification failed");
      $finish;
   end

endmodule

`default_nettype wire

[diamond_zone_marker_top.f]
sv/dzm_pkg.sv
sv/dzm_csr.sv
sv/dzm_front.sv
sv/dzm_queue.sv
sv/dzm_back.sv
sv/diamond_zone_marker_top.sv
tb/diamond_zone_marker_top_tb.sv
